// ===== rtl/spike_period_harmonic_classifier_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef SPIKE_PERIOD_HARMONIC_CLASSIFIER_TOP_MACROS_SVH
`define SPIKE_PERIOD_HARMONIC_CLASSIFIER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPHC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPHC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sphc_pkg.sv =====
package sphc_pkg;

   localparam int TIME_W      = 64;
   localparam int LAT_W       = 32;
   localparam int PERIOD_W    = 32;
   localparam int COUNT_W     = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam int BIG_INTERVAL_BITS = 40;
   localparam int PROD_W            = 48;
   localparam int SUM_W             = COUNT_W + 2;
   localparam int FRAC_W            = SUM_W + 8;

   localparam logic [PROD_W-1:0] SCALE   = PROD_W'(100);
   localparam logic [PROD_W-1:0] WIN1_LO = PROD_W'(85);
   localparam logic [PROD_W-1:0] WIN1_HI = PROD_W'(115);
   localparam logic [PROD_W-1:0] WIN2_LO = PROD_W'(185);
   localparam logic [PROD_W-1:0] WIN2_HI = PROD_W'(215);
   localparam logic [PROD_W-1:0] WIN3_LO = PROD_W'(285);
   localparam logic [PROD_W-1:0] WIN3_HI = PROD_W'(315);

   localparam logic [FRAC_W-1:0] FRAC_SCALE    = FRAC_W'(100);
   localparam logic [FRAC_W-1:0] FRAC_PERIODIC = FRAC_W'(30);
   localparam logic [FRAC_W-1:0] FRAC_WEAK     = FRAC_W'(15);

   localparam logic [COUNT_W-1:0] MIN_SPIKES = COUNT_W'(10);

   localparam logic [LAT_W-1:0]    THRESHOLD_RESET = LAT_W'(400);
   localparam logic [PERIOD_W-1:0] PERIOD_RESET    = PERIOD_W'(23400);
   localparam logic [COUNT_W-1:0]  LIMIT_RESET     = COUNT_W'(2000000);

   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD    = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT     = CSR_INDEX_W'(2);

   typedef enum logic [2:0] {
      CLASS_NONE    = 3'd0,
      CLASS_ONE_T   = 3'd1,
      CLASS_TWO_T   = 3'd2,
      CLASS_THREE_T = 3'd3,
      CLASS_OTHER   = 3'd4
   } interval_class_type;

   typedef enum logic [1:0] {
      VERDICT_INSUFFICIENT = 2'd0,
      VERDICT_PERIODIC     = 2'd1,
      VERDICT_WEAK         = 2'd2,
      VERDICT_NONE         = 2'd3
   } verdict_type;

   typedef struct packed {
      logic [COUNT_W-1:0] spikes;
      logic [COUNT_W-1:0] one;
      logic [COUNT_W-1:0] two;
      logic [COUNT_W-1:0] three;
      logic [COUNT_W-1:0] other;
   } counts_type;

endpackage

// ===== rtl/sphc_window.sv =====
module sphc_window (
   input  logic [sphc_pkg::TIME_W-1:0]   interval,
   input  logic [sphc_pkg::PERIOD_W-1:0] period,
   output sphc_pkg::interval_class_type  interval_class
);

   logic                          small_interval;
   logic [sphc_pkg::PROD_W-1:0]   scaled;
   logic [sphc_pkg::PROD_W-1:0]   period_w;
   logic                          in_one;
   logic                          in_two;
   logic                          in_three;

   assign small_interval =
      (interval[sphc_pkg::TIME_W-1:sphc_pkg::BIG_INTERVAL_BITS] == '0);
   assign scaled = sphc_pkg::PROD_W'(interval[sphc_pkg::BIG_INTERVAL_BITS-1:0])
                   * sphc_pkg::SCALE;
   assign period_w = sphc_pkg::PROD_W'(period);

   assign in_one   = (scaled >= period_w * sphc_pkg::WIN1_LO)
                     && (scaled <= period_w * sphc_pkg::WIN1_HI);
   assign in_two   = (scaled >= period_w * sphc_pkg::WIN2_LO)
                     && (scaled <= period_w * sphc_pkg::WIN2_HI);
   assign in_three = (scaled >= period_w * sphc_pkg::WIN3_LO)
                     && (scaled <= period_w * sphc_pkg::WIN3_HI);

   always_comb begin
      if (!small_interval) begin
         interval_class = sphc_pkg::CLASS_OTHER;
      end else if (in_one) begin
         interval_class = sphc_pkg::CLASS_ONE_T;
      end else if (in_two) begin
         interval_class = sphc_pkg::CLASS_TWO_T;
      end else if (in_three) begin
         interval_class = sphc_pkg::CLASS_THREE_T;
      end else begin
         interval_class = sphc_pkg::CLASS_OTHER;
      end
   end

endmodule

// ===== rtl/sphc_verdict.sv =====
module sphc_verdict (
   input  sphc_pkg::counts_type  counts,
   output sphc_pkg::verdict_type verdict
);

   logic [sphc_pkg::COUNT_W-1:0] intervals;
   logic [sphc_pkg::SUM_W-1:0]   harmonic_sum;
   logic [sphc_pkg::FRAC_W-1:0]  harmonic_scaled;
   logic [sphc_pkg::FRAC_W-1:0]  intervals_w;

   assign intervals    = counts.spikes - sphc_pkg::COUNT_W'(1);
   assign harmonic_sum = sphc_pkg::SUM_W'(counts.one) + sphc_pkg::SUM_W'(counts.two)
                         + sphc_pkg::SUM_W'(counts.three);
   assign harmonic_scaled = sphc_pkg::FRAC_W'(harmonic_sum) * sphc_pkg::FRAC_SCALE;
   assign intervals_w     = sphc_pkg::FRAC_W'(intervals);

   always_comb begin
      if (counts.spikes < sphc_pkg::MIN_SPIKES) begin
         verdict = sphc_pkg::VERDICT_INSUFFICIENT;
      end else if (harmonic_scaled > intervals_w * sphc_pkg::FRAC_PERIODIC) begin
         verdict = sphc_pkg::VERDICT_PERIODIC;
      end else if (harmonic_scaled > intervals_w * sphc_pkg::FRAC_WEAK) begin
         verdict = sphc_pkg::VERDICT_WEAK;
      end else begin
         verdict = sphc_pkg::VERDICT_NONE;
      end
   end

endmodule

// ===== rtl/spike_period_harmonic_classifier_top.sv =====
// Channel   Direction  Handshake            Contents
// req_      in         req_valid/req_ready  timestamp, latency, last_sample
// rsp_      out        rsp_valid/rsp_ready  spike flag, class, verdict, counts
// csr_      in         csr_write_enable     register index and write data
//
// An item is captured in the input register and passes through the classification logic
// into the result register, from which its result is offered.
// A new item is accepted in every cycle unless the result stalls; the run counters update as an item moves on.
// Reset is synchronous and restores the default register values and an empty run.
// When the result is not taken, the input register holds one more item and then stalls.
module spike_period_harmonic_classifier_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [sphc_pkg::TIME_W-1:0]       req_timestamp,
   input  logic [sphc_pkg::LAT_W-1:0]        req_latency,
   input  logic                              req_last_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_spike_recorded,
   output logic [2:0]                        rsp_interval_class,
   output logic                              rsp_verdict_valid,
   output logic [1:0]                        rsp_verdict,
   output logic [sphc_pkg::COUNT_W-1:0]      rsp_spike_total,
   output logic [sphc_pkg::COUNT_W-1:0]      rsp_one_period_count,
   output logic [sphc_pkg::COUNT_W-1:0]      rsp_two_period_count,
   output logic [sphc_pkg::COUNT_W-1:0]      rsp_three_period_count,
   output logic [sphc_pkg::COUNT_W-1:0]      rsp_other_interval_count,
   input  logic                              csr_write_enable,
   input  logic [sphc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [sphc_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   logic [sphc_pkg::LAT_W-1:0]    threshold_ff;
   logic [sphc_pkg::PERIOD_W-1:0] period_ff;
   logic [sphc_pkg::COUNT_W-1:0]  limit_ff;

   logic                          in_valid_ff;
   logic [sphc_pkg::TIME_W-1:0]   in_timestamp_ff;
   logic [sphc_pkg::LAT_W-1:0]    in_latency_ff;
   logic                          in_last_ff;

   logic [sphc_pkg::TIME_W-1:0]   prev_time_ff;
   logic [sphc_pkg::TIME_W-1:0]   prev_time_in;
   sphc_pkg::counts_type          counts_ff;
   sphc_pkg::counts_type          counts_in;
   sphc_pkg::counts_type          counts_upd;

   logic                          rsp_valid_ff;
   logic                          rsp_spike_ff;
   sphc_pkg::interval_class_type  rsp_class_ff;
   logic                          rsp_verdict_valid_ff;
   sphc_pkg::verdict_type         rsp_verdict_ff;
   sphc_pkg::counts_type          rsp_counts_ff;

   logic                          advance;
   logic                          spike;
   logic                          has_interval;
   logic [sphc_pkg::TIME_W-1:0]   interval;
   sphc_pkg::interval_class_type  window_class;
   sphc_pkg::interval_class_type  item_class;
   sphc_pkg::verdict_type         run_verdict;
   sphc_pkg::verdict_type         item_verdict;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= sphc_pkg::THRESHOLD_RESET;
         period_ff    <= sphc_pkg::PERIOD_RESET;
         limit_ff     <= sphc_pkg::LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            sphc_pkg::CSR_THRESHOLD: threshold_ff <= csr_write_data;
            sphc_pkg::CSR_PERIOD:    period_ff    <= csr_write_data;
            sphc_pkg::CSR_LIMIT:     limit_ff     <= csr_write_data[sphc_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_timestamp_ff <= req_timestamp;
         in_latency_ff   <= req_latency;
         in_last_ff      <= req_last_sample;
      end
   end

   assign spike        = (in_latency_ff > threshold_ff) && (counts_ff.spikes < limit_ff);
   assign has_interval = spike && (counts_ff.spikes != '0);
   assign interval     = in_timestamp_ff - prev_time_ff;

   sphc_window u_window (
      .interval       (interval),
      .period         (period_ff),
      .interval_class (window_class)
   );

   assign item_class = has_interval ? window_class : sphc_pkg::CLASS_NONE;

   always_comb begin
      counts_upd = counts_ff;
      if (spike) begin
         counts_upd.spikes = counts_ff.spikes + sphc_pkg::COUNT_W'(1);
      end
      case (item_class)
         sphc_pkg::CLASS_ONE_T:   counts_upd.one   = counts_ff.one + sphc_pkg::COUNT_W'(1);
         sphc_pkg::CLASS_TWO_T:   counts_upd.two   = counts_ff.two + sphc_pkg::COUNT_W'(1);
         sphc_pkg::CLASS_THREE_T: counts_upd.three = counts_ff.three + sphc_pkg::COUNT_W'(1);
         sphc_pkg::CLASS_OTHER:   counts_upd.other = counts_ff.other + sphc_pkg::COUNT_W'(1);
         default: ;
      endcase
   end

   sphc_verdict u_verdict (
      .counts  (counts_upd),
      .verdict (run_verdict)
   );

   assign item_verdict = in_last_ff ? run_verdict : sphc_pkg::VERDICT_INSUFFICIENT;

   // The last item of a run ends it, so the run state starts afresh.
   always_comb begin
      if (in_last_ff) begin
         counts_in    = '0;
         prev_time_in = '0;
      end else begin
         counts_in    = counts_upd;
         prev_time_in = spike ? in_timestamp_ff : prev_time_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counts_ff    <= '0;
         prev_time_ff <= '0;
      end else if (advance) begin
         counts_ff    <= counts_in;
         prev_time_ff <= prev_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_spike_ff         <= spike;
         rsp_class_ff         <= item_class;
         rsp_verdict_valid_ff <= in_last_ff;
         rsp_verdict_ff       <= item_verdict;
         rsp_counts_ff        <= counts_upd;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_spike_recorded       = rsp_spike_ff;
   assign rsp_interval_class       = rsp_class_ff;
   assign rsp_verdict_valid        = rsp_verdict_valid_ff;
   assign rsp_verdict              = rsp_verdict_ff;
   assign rsp_spike_total          = rsp_counts_ff.spikes;
   assign rsp_one_period_count     = rsp_counts_ff.one;
   assign rsp_two_period_count     = rsp_counts_ff.two;
   assign rsp_three_period_count   = rsp_counts_ff.three;
   assign rsp_other_interval_count = rsp_counts_ff.other;

endmodule

// ===== rtl/sphc_checker.sv =====
`include "spike_period_harmonic_classifier_top_macros.svh"

module sphc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic                              rsp_spike_recorded,
   input logic [2:0]                        rsp_interval_class,
   input logic                              rsp_verdict_valid,
   input logic [1:0]                        rsp_verdict,
   input logic [sphc_pkg::COUNT_W-1:0]      rsp_spike_total,
   input logic [sphc_pkg::COUNT_W-1:0]      rsp_one_period_count,
   input logic [sphc_pkg::COUNT_W-1:0]      rsp_two_period_count,
   input logic [sphc_pkg::COUNT_W-1:0]      rsp_three_period_count,
   input logic [sphc_pkg::COUNT_W-1:0]      rsp_other_interval_count
);

   logic [sphc_pkg::SUM_W-1:0] interval_sum;
   logic [sphc_pkg::SUM_W-1:0] expected_sum;

   // Every spike but the first of a run closes exactly one interval.
   assign interval_sum = sphc_pkg::SUM_W'(rsp_one_period_count)
                         + sphc_pkg::SUM_W'(rsp_two_period_count)
                         + sphc_pkg::SUM_W'(rsp_three_period_count)
                         + sphc_pkg::SUM_W'(rsp_other_interval_count)
                         + sphc_pkg::SUM_W'(rsp_spike_total != '0);
   assign expected_sum = sphc_pkg::SUM_W'(rsp_spike_total);

   `SPHC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_spike_total) && $stable(rsp_verdict),
      "result item changed while stalled")

   `SPHC_ASSERT_NOW(a_class_needs_spike, rsp_valid && !rsp_spike_recorded,
      rsp_interval_class == sphc_pkg::CLASS_NONE,
      "interval class reported without a recorded spike")

   `SPHC_ASSERT_NOW(a_verdict_only_last, rsp_valid && !rsp_verdict_valid,
      rsp_verdict == sphc_pkg::VERDICT_INSUFFICIENT,
      "verdict reported on an item that is not the last")

   `SPHC_ASSERT_NOW(a_insufficient, rsp_valid && rsp_verdict_valid
      && (rsp_spike_total < sphc_pkg::MIN_SPIKES),
      rsp_verdict == sphc_pkg::VERDICT_INSUFFICIENT,
      "verdict given with too few spikes")

   `SPHC_ASSERT_NOW(a_interval_total, rsp_valid, interval_sum == expected_sum,
      "interval counts disagree with the spike total")

endmodule

bind spike_period_harmonic_classifier_top sphc_checker u_sphc_checker (.*);

// ===== sim/tb.sv =====
module tb;
   import sphc_pkg::*;

   typedef struct {
      logic [TIME_W-1:0] timestamp;
      logic [LAT_W-1:0]  latency;
      logic              last;
   } probe_sample_type;

   typedef struct {
      logic               spike;
      interval_class_type cls;
      logic               verdict_valid;
      verdict_type        verdict;
      logic [COUNT_W-1:0] total;
      logic [COUNT_W-1:0] one;
      logic [COUNT_W-1:0] two;
      logic [COUNT_W-1:0] three;
      logic [COUNT_W-1:0] other;
   } sample_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [TIME_W-1:0]      req_timestamp = '0;
   logic [LAT_W-1:0]       req_latency = '0;
   logic                   req_last_sample = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_spike_recorded;
   logic [2:0]             rsp_interval_class;
   logic                   rsp_verdict_valid;
   logic [1:0]             rsp_verdict;
   logic [COUNT_W-1:0]     rsp_spike_total;
   logic [COUNT_W-1:0]     rsp_one_period_count;
   logic [COUNT_W-1:0]     rsp_two_period_count;
   logic [COUNT_W-1:0]     rsp_three_period_count;
   logic [COUNT_W-1:0]     rsp_other_interval_count;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   // Register copies and run state of the classifier as the testbench sees it.
   logic [LAT_W-1:0]    cfg_threshold = THRESHOLD_RESET;
   logic [PERIOD_W-1:0] cfg_period = PERIOD_RESET;
   logic [COUNT_W-1:0]  cfg_limit = LIMIT_RESET;
   logic [TIME_W-1:0]   last_spike_time = '0;
   logic [COUNT_W-1:0]  run_spikes = '0;
   logic [COUNT_W-1:0]  run_one = '0;
   logic [COUNT_W-1:0]  run_two = '0;
   logic [COUNT_W-1:0]  run_three = '0;
   logic [COUNT_W-1:0]  run_other = '0;

   probe_sample_type  pending_samples[$];
   probe_sample_type  in_flight;
   sample_result_type sample_results[$];
   sample_result_type oldest;
   logic [TIME_W-1:0] stamp_cursor = '0;

   int queued_total = 0;
   int sent_count = 0;
   int done_count = 0;
   int mismatches = 0;
   int send_gap = 0;
   int recv_stall = 0;
   bit holding = 1'b0;
   bit no_idle = 1'b0;

   spike_period_harmonic_classifier_top dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_timestamp            (req_timestamp),
      .req_latency              (req_latency),
      .req_last_sample          (req_last_sample),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_spike_recorded       (rsp_spike_recorded),
      .rsp_interval_class       (rsp_interval_class),
      .rsp_verdict_valid        (rsp_verdict_valid),
      .rsp_verdict              (rsp_verdict),
      .rsp_spike_total          (rsp_spike_total),
      .rsp_one_period_count     (rsp_one_period_count),
      .rsp_two_period_count     (rsp_two_period_count),
      .rsp_three_period_count   (rsp_three_period_count),
      .rsp_other_interval_count (rsp_other_interval_count),
      .csr_write_enable         (csr_write_enable),
      .csr_index                (csr_index),
      .csr_write_data           (csr_write_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic sample_result_type predict_sample(input probe_sample_type s);
      sample_result_type r;
      logic [TIME_W-1:0] span;
      logic [TIME_W-1:0] span100;
      logic [TIME_W-1:0] t;
      logic [TIME_W-1:0] harm;
      logic [TIME_W-1:0] n;
      r.spike = 1'b0;
      r.cls = CLASS_NONE;
      r.verdict_valid = 1'b0;
      r.verdict = VERDICT_INSUFFICIENT;
      t = TIME_W'(cfg_period);
      if (s.latency > cfg_threshold && run_spikes < cfg_limit) begin
         r.spike = 1'b1;
         if (run_spikes != '0) begin
            span = s.timestamp - last_spike_time;
            span100 = span * 100;
            if (span >= 64'h0000_0100_0000_0000) begin
               r.cls = CLASS_OTHER;
            end else if (span100 >= 85 * t && span100 <= 115 * t) begin
               r.cls = CLASS_ONE_T;
            end else if (span100 >= 185 * t && span100 <= 215 * t) begin
               r.cls = CLASS_TWO_T;
            end else if (span100 >= 285 * t && span100 <= 315 * t) begin
               r.cls = CLASS_THREE_T;
            end else begin
               r.cls = CLASS_OTHER;
            end
            case (r.cls)
               CLASS_ONE_T: begin
                  run_one = run_one + 1'b1;
               end
               CLASS_TWO_T: begin
                  run_two = run_two + 1'b1;
               end
               CLASS_THREE_T: begin
                  run_three = run_three + 1'b1;
               end
               default: begin
                  run_other = run_other + 1'b1;
               end
            endcase
         end
         last_spike_time = s.timestamp;
         run_spikes = run_spikes + 1'b1;
      end
      r.total = run_spikes;
      r.one = run_one;
      r.two = run_two;
      r.three = run_three;
      r.other = run_other;
      if (s.last) begin
         r.verdict_valid = 1'b1;
         if (run_spikes < 10) begin
            r.verdict = VERDICT_INSUFFICIENT;
         end else begin
            n = TIME_W'(run_spikes) - 1;
            harm = TIME_W'(run_one) + TIME_W'(run_two) + TIME_W'(run_three);
            if (harm * 100 > n * 30) begin
               r.verdict = VERDICT_PERIODIC;
            end else if (harm * 100 > n * 15) begin
               r.verdict = VERDICT_WEAK;
            end else begin
               r.verdict = VERDICT_NONE;
            end
         end
         last_spike_time = '0;
         run_spikes = '0;
         run_one = '0;
         run_two = '0;
         run_three = '0;
         run_other = '0;
      end
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch in %s: got %0d, expected %0d", what, got, want);
      mismatches++;
   endtask

   task automatic push_after(input logic [TIME_W-1:0] step, input logic [LAT_W-1:0] lat,
                             input logic last);
      probe_sample_type s;
      stamp_cursor = stamp_cursor + step;
      s.timestamp = stamp_cursor;
      s.latency = lat;
      s.last = last;
      pending_samples.push_back(s);
      queued_total++;
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_THRESHOLD: begin
            cfg_threshold = data;
         end
         CSR_PERIOD: begin
            cfg_period = data;
         end
         CSR_LIMIT: begin
            cfg_limit = data[COUNT_W-1:0];
         end
         default: begin
         end
      endcase
      @(negedge clock);
   endtask

   task automatic settle();
      do @(posedge clock); while (done_count != queued_total);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] threshold,
                            input logic [CSR_DATA_W-1:0] period,
                            input logic [CSR_DATA_W-1:0] limit);
      settle();
      write_csr(CSR_THRESHOLD, threshold);
      write_csr(CSR_PERIOD, period);
      write_csr(CSR_LIMIT, limit);
   endtask

   // A run of samples, about harm_pct percent of them spaced near a multiple of the period, with jitter.
   task automatic add_run(input int len, input int harm_pct, input bit finish);
      int                i;
      int                pick;
      int                k;
      logic [TIME_W-1:0] t;
      logic [TIME_W-1:0] step;
      logic [LAT_W-1:0]  lat;
      logic [LAT_W:0]    wide;
      t = TIME_W'(cfg_period);
      stamp_cursor = {$urandom, $urandom};
      for (i = 0; i < len; i++) begin
         pick = $urandom_range(0, 99);
         k = $urandom_range(1, 3);
         if (pick < harm_pct) begin
            step = t * (100 * k - 20 + $urandom_range(0, 40)) / 100;
         end else if (pick < harm_pct + (100 - harm_pct) * 3 / 10) begin
            step = t * $urandom_range(0, 400) / 100;
         end else begin
            step = {$urandom, $urandom};
         end
         if ($urandom_range(0, 99) < 85) begin
            wide = {1'b0, cfg_threshold} + 1 + $urandom_range(0, 2000);
            if (wide[LAT_W] || $urandom_range(0, 9) == 0) begin
               lat = '1;
            end else begin
               lat = wide[LAT_W-1:0];
            end
         end else if (cfg_threshold == '0) begin
            lat = '0;
         end else begin
            lat = $urandom_range(0, cfg_threshold);
         end
         push_after(step, lat, finish && i == len - 1);
      end
   endtask

   task automatic add_noise(input int count);
      int i;
      for (i = 0; i < count; i++) begin
         stamp_cursor = {$urandom, $urandom};
         push_after('0, $urandom, $urandom_range(0, 9) == 0);
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sample_results.push_back(predict_sample(in_flight));
            sent_count++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (holding) begin
               req_valid <= 1'b0;
               if (done_count == sent_count) holding = 1'b0;
            end else if (pending_samples.size() != 0) begin
               in_flight = pending_samples.pop_front();
               req_valid <= 1'b1;
               req_timestamp <= in_flight.timestamp;
               req_latency <= in_flight.latency;
               req_last_sample <= in_flight.last;
               send_gap = pick_gap();
               if ($urandom_range(0, 149) == 0) holding = 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            done_count <= done_count + 1;
            if (sample_results.size() == 0) begin
               report_mismatch("unexpected item", 64'(rsp_spike_total), 64'(0));
            end else begin
               oldest = sample_results.pop_front();
               if (rsp_spike_recorded !== oldest.spike)
                  report_mismatch("spike_recorded", 64'(rsp_spike_recorded),
                                  64'(oldest.spike));
               if (rsp_interval_class !== oldest.cls)
                  report_mismatch("interval_class", 64'(rsp_interval_class),
                                  64'(oldest.cls));
               if (rsp_verdict_valid !== oldest.verdict_valid)
                  report_mismatch("verdict_valid", 64'(rsp_verdict_valid),
                                  64'(oldest.verdict_valid));
               if (rsp_verdict !== oldest.verdict)
                  report_mismatch("verdict", 64'(rsp_verdict), 64'(oldest.verdict));
               if (rsp_spike_total !== oldest.total)
                  report_mismatch("spike_total", 64'(rsp_spike_total), 64'(oldest.total));
               if (rsp_one_period_count !== oldest.one)
                  report_mismatch("one_period_count", 64'(rsp_one_period_count),
                                  64'(oldest.one));
               if (rsp_two_period_count !== oldest.two)
                  report_mismatch("two_period_count", 64'(rsp_two_period_count),
                                  64'(oldest.two));
               if (rsp_three_period_count !== oldest.three)
                  report_mismatch("three_period_count", 64'(rsp_three_period_count),
                                  64'(oldest.three));
               if (rsp_other_interval_count !== oldest.other)
                  report_mismatch("other_interval_count", 64'(rsp_other_interval_count),
                                  64'(oldest.other));
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_stall = pick_gap();
         end
      end
   end

   initial begin
      int                  phase;
      int                  runs;
      int                  random_goal;
      int                  roll;
      logic [CSR_DATA_W-1:0] thr_pick;
      logic [CSR_DATA_W-1:0] period_pick;
      logic [CSR_DATA_W-1:0] limit_pick;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Register defaults: threshold equality, the edges of every window and a wrap of time.
      stamp_cursor = 64'd100;
      push_after(64'd0, 32'd400, 1'b0);
      push_after(64'd900, 32'd401, 1'b0);
      push_after(64'd19890, '1, 1'b0);
      push_after(64'd26910, '1, 1'b0);
      push_after(64'd26911, '1, 1'b0);
      push_after(64'd19889, '1, 1'b0);
      push_after(64'd43290, '1, 1'b0);
      push_after(64'd50310, '1, 1'b0);
      push_after(64'd66690, '1, 1'b0);
      push_after(64'd73710, '1, 1'b0);
      push_after(64'd73711, '1, 1'b0);
      push_after(64'h0000_0100_0000_0000, '1, 1'b0);
      stamp_cursor = 64'hFFFF_FFFF_FFFF_F000;
      push_after(64'd0, '1, 1'b0);
      push_after(64'd23400, '1, 1'b0);
      push_after(64'd5, 32'd0, 1'b1);
      push_after(64'd7, '1, 1'b1);
      stamp_cursor = '1;
      push_after(64'd0, 32'd0, 1'b0);

      // A period of 1 with a zero threshold.
      configure(32'd0, 32'd1, 32'h00FF_FFFF);
      stamp_cursor = 64'h8000_0000_0000_0000;
      push_after(64'd10, 32'd1, 1'b0);
      push_after(64'd0, 32'd1, 1'b0);
      push_after(64'd1, 32'd5, 1'b0);
      push_after(64'd2, 32'd1, 1'b0);
      push_after(64'd3, 32'd1, 1'b0);
      push_after(64'd4, 32'd1, 1'b0);
      push_after(64'd7, 32'd0, 1'b1);

      // With a zero period only a zero interval falls in the first window.
      configure(32'd0, 32'd0, 32'h00FF_FFFF);
      push_after(64'd3, '1, 1'b0);
      push_after(64'd0, '1, 1'b0);
      push_after(64'd9, '1, 1'b1);

      random_goal = queued_total + 450;
      phase = 0;
      while (queued_total < random_goal) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) thr_pick = $urandom_range(100, 1000);
         else if (roll < 80) thr_pick = '0;
         else if (roll < 90) thr_pick = $urandom;
         else thr_pick = '1;
         roll = $urandom_range(0, 99);
         if (roll < 70) period_pick = $urandom_range(1000, 100000);
         else if (roll < 80) period_pick = $urandom;
         else if (roll < 90) period_pick = 32'd1;
         else period_pick = '1;
         roll = $urandom_range(0, 99);
         if (roll < 60) limit_pick = 32'd2000000;
         else if (roll < 85) limit_pick = $urandom_range(5, 40);
         else if (roll < 95) limit_pick = 32'h00FF_FFFF;
         else limit_pick = '0;
         case (phase)
            0: configure('1, '1, 32'h00FF_FFFF);
            1: configure(32'd0, '1, 32'd0);
            2: configure(thr_pick, period_pick, 32'd2000000);
            3: configure(thr_pick, period_pick, 32'd6);
            default: configure(thr_pick, period_pick, limit_pick);
         endcase
         no_idle = ($urandom_range(0, 3) == 0);
         runs = (phase < 2) ? 1 : $urandom_range(2, 4);
         add_noise($urandom_range(2, 6));
         repeat (runs - 1) begin
            case ($urandom_range(0, 3))
               0: add_run($urandom_range(10, 35), 95, 1'b1);
               1: add_run($urandom_range(10, 35), 40, 1'b1);
               2: add_run($urandom_range(10, 35), 15, 1'b1);
               default: add_run($urandom_range(10, 35), 0, 1'b1);
            endcase
         end
         // The last run of a phase may be left open so that the next settings apply mid-run.
         add_run($urandom_range(10, 35), 40, phase != 2 && $urandom_range(0, 1) == 1);
         phase++;
      end

      settle();
      repeat (10) @(posedge clock);
      if (sample_results.size() != 0)
         report_mismatch("results never produced", 64'(sample_results.size()), 64'(0));
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #(12 * 1000000);
      $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sphc_pkg.sv
rtl/sphc_window.sv
rtl/sphc_verdict.sv
rtl/spike_period_harmonic_classifier_top.sv
rtl/sphc_checker.sv
sim/tb.sv
